// File: src/lease_table_oldest_replace_unit_assert.svh
// Assertion macros used by the lease table sequencer (lto_scan).
`ifndef LEASE_TABLE_OLDEST_REPLACE_UNIT_ASSERT_SVH
`define LEASE_TABLE_OLDEST_REPLACE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Implication or plain property, checked on clk_i outside of reset.
`define LTO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lease table assertion failed");

// Condition that must never hold outside of reset.
`define LTO_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lease table forbidden condition seen");

`else

`define LTO_ASSERT(lbl, prop)
`define LTO_ASSERT_NEVER(lbl, cond)

`endif

`endif

// File: src/lto_pkg.sv
// Types, widths and codes shared by the lease table modules.
package lto_pkg;

  localparam int unsigned DefSlots = 10;

  localparam int unsigned MacW     = 48;
  localparam int unsigned StampW   = 64;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned HostW    = 8;
  localparam int unsigned PrefixW  = 24;
  localparam int unsigned IpW      = 32;
  localparam int unsigned OutcomeW = 2;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [HostW-1:0]   BaseHostRst = 8'd231;
  localparam logic [PrefixW-1:0] PrefixRst   = 24'hC0A8C8;

  // Register select, taken from paddr[2].
  localparam logic RegBaseHost = 1'b0;
  localparam logic RegPrefix   = 1'b1;

  typedef enum logic [OutcomeW-1:0] {
    OUT_MATCH = 2'd0,
    OUT_EMPTY = 2'd1,
    OUT_EVICT = 2'd2
  } lto_outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_OUT
  } lto_state_e;

  typedef struct packed {
    logic [MacW-1:0]   mac;
    logic [StampW-1:0] stamp;
  } lto_entry_t;

  typedef struct packed {
    logic [HostW-1:0]   base_host;
    logic [PrefixW-1:0] subnet_prefix;
  } lto_cfg_t;

endpackage

// File: src/lto_req_if.sv
// Request channel: client address and current time.
interface lto_req_if
  import lto_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MacW-1:0]   mac_addr;
  logic [StampW-1:0] now_time;

  modport source (output valid, output mac_addr, output now_time, input ready);
  modport sink (input valid, input mac_addr, input now_time, output ready);
endinterface

// File: src/lto_rsp_if.sv
// Result channel: chosen slot, assigned address and outcome.
interface lto_rsp_if
  import lto_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SlotW-1:0]    slot;
  logic [IpW-1:0]      lease_ip;
  logic [OutcomeW-1:0] outcome;

  modport source (output valid, output slot, output lease_ip, output outcome,
                  input ready);
  modport sink (input valid, input slot, input lease_ip, input outcome,
                output ready);
endinterface

// File: src/lease_table_oldest_replace_unit.sv
// Lease table top level: one request at a time, slots scanned through a memory with one read port.
// A request's result follows the scan, the write-back and the output register; the scan makes
// one slot read per cycle until the first matching or free slot, else it reads all SLOTS slots.
// A new request is taken only after the last result is loaded into the output register.
// Reset: all slots read as empty, base_host = 231, subnet_prefix = 192.168.200.
// No clearing pass follows reset; the first request may be accepted at once.
module lease_table_oldest_replace_unit
  import lto_pkg::*;
#(
  parameter int unsigned SLOTS = DefSlots
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  lto_req_if.sink             req,
  lto_rsp_if.source           rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  lto_cfg_t        cfg;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  lto_entry_t      rd_entry;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  lto_entry_t      wr_entry;

  lto_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lto_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry)
  );

  lto_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req),
    .rsp        (rsp),
    .cfg_i      (cfg),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_entry_i (rd_entry),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_entry_o (wr_entry)
  );

endmodule

// File: src/lto_cfg_regs.sv
// APB register block holding the host octet base and the subnet prefix.
module lto_cfg_regs
  import lto_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output lto_cfg_t            cfg_o
);

  lto_cfg_t cfg_q;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_host     <= BaseHostRst;
      cfg_q.subnet_prefix <= PrefixRst;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegBaseHost: cfg_q.base_host     <= pwdata[HostW-1:0];
        RegPrefix:   cfg_q.subnet_prefix <= pwdata[PrefixW-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegBaseHost: prdata = {{(ApbDataW-HostW){1'b0}}, cfg_q.base_host};
      RegPrefix:   prdata = {{(ApbDataW-PrefixW){1'b0}}, cfg_q.subnet_prefix};
      default:     prdata = '0;
    endcase
  end

endmodule

// File: src/lto_slot_mem.sv
// Slot memory with one registered read port, one write port and per-slot valid bits.
module lto_slot_mem
  import lto_pkg::*;
#(
  parameter int unsigned SLOTS = DefSlots,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output lto_entry_t      rd_entry_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  lto_entry_t      wr_entry_i
);

  lto_entry_t       mem_q [SLOTS];
  logic [SLOTS-1:0] valid_q;
  lto_entry_t       rd_data_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // A slot never written since reset reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule

// File: src/lto_scan.sv
// Request sequencer: scans the slots one per cycle, writes back the choice, drives the result.
`include "lease_table_oldest_replace_unit_assert.svh"

module lto_scan
  import lto_pkg::*;
#(
  parameter int unsigned SLOTS = DefSlots,
  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  lto_req_if.sink         req,
  lto_rsp_if.source       rsp,
  input  lto_cfg_t        cfg_i,
  output logic            rd_en_o,
  output logic [IdxW-1:0] rd_addr_o,
  input  lto_entry_t      rd_entry_i,
  output logic            wr_en_o,
  output logic [IdxW-1:0] wr_addr_o,
  output lto_entry_t      wr_entry_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  lto_state_e        state_q, state_d;
  logic [IdxW-1:0]   idx_q;
  logic [MacW-1:0]   mac_q;
  logic [StampW-1:0] stamp_q;
  logic [StampW-1:0] min_stamp_q;
  logic [IdxW-1:0]   min_idx_q;
  logic [IdxW-1:0]   pick_q;
  lto_outcome_e      kind_q;
  logic              out_valid_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [IpW-1:0]    out_ip_q;
  lto_outcome_e      out_kind_q;

  logic             accept;
  logic             hit_match;
  logic             hit_empty;
  logic             hit;
  logic             last;
  logic             new_min;
  logic             out_load;
  logic [HostW-1:0] host_oct;

  assign accept    = req.valid && req.ready;
  assign hit_match = (rd_entry_i.mac == mac_q);
  assign hit_empty = (rd_entry_i.mac == '0);
  assign hit       = hit_match || hit_empty;
  assign last      = (idx_q == LastIdx);
  assign new_min   = (idx_q == '0) || (rd_entry_i.stamp < min_stamp_q);
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || rsp.ready);
  assign host_oct  = cfg_i.base_host + HostW'(pick_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SCAN;
      ST_SCAN:  if (hit || last) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = (state_q == ST_IDLE);
    rd_en_o    = accept || ((state_q == ST_SCAN) && !hit && !last);
    rd_addr_o  = (state_q == ST_SCAN) ? idx_q + 1'b1 : '0;
    wr_en_o    = (state_q == ST_WRITE);
    wr_addr_o  = pick_q;
    wr_entry_o = '{mac: mac_q, stamp: stamp_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mac_q   <= req.mac_addr;
      stamp_q <= req.now_time;
      idx_q   <= '0;
    end
    if (state_q == ST_SCAN) begin
      if (new_min) begin
        min_stamp_q <= rd_entry_i.stamp;
        min_idx_q   <= idx_q;
      end
      if (hit) begin
        pick_q <= idx_q;
        kind_q <= hit_match ? OUT_MATCH : OUT_EMPTY;
      end else if (last) begin
        // No match and no free slot: the oldest stamp loses its slot.
        pick_q <= new_min ? idx_q : min_idx_q;
        kind_q <= OUT_EVICT;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
    if (out_load) begin
      out_slot_q <= SlotW'(pick_q);
      out_ip_q   <= {cfg_i.subnet_prefix, host_oct};
      out_kind_q <= kind_q;
    end
  end

  assign rsp.valid    = out_valid_q;
  assign rsp.slot     = out_slot_q;
  assign rsp.lease_ip = out_ip_q;
  assign rsp.outcome  = out_kind_q;

  `LTO_ASSERT(a_wr_in_range, wr_en_o |-> (wr_addr_o <= LastIdx))
  `LTO_ASSERT(a_evict_full_scan, ((state_q == ST_WRITE) && (kind_q == OUT_EVICT)) |-> last)
  `LTO_ASSERT(a_rsp_after_write, $rose(out_valid_q) |-> $past(state_q == ST_OUT))
  `LTO_ASSERT(a_accept_starts_scan, accept |=> (state_q == ST_SCAN))
  `LTO_ASSERT_NEVER(a_no_read_while_write, rd_en_o && wr_en_o)

endmodule
